### rtl/core/pidpi_pkg.sv
// Shared types, widths and register codes for the PID position/incremental core.
package pidpi_pkg;

  localparam int DATA_W                 = 16;
  localparam int ERR_W                  = 17;
  localparam int DERR_W                 = 19;
  localparam int GAIN_W                 = 24;
  localparam int LIMIT_W                = 15;
  localparam int GATE_W                 = 16;
  localparam int CFG_DATA_W             = 24;
  localparam int CFG_INDEX_W            = 3;
  localparam int GAIN_FRAC_BITS_DEFAULT = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CONTROL_MODE   = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_OUTPUT_LIMIT   = 3'd5,
    REG_MAX_ERROR      = 3'd6,
    REG_DEADBAND_WIDTH = 3'd7
  } cfg_index_t;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } control_mode_t;

  typedef struct packed {
    control_mode_t              control_mode;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic        [LIMIT_W-1:0]  integral_limit;
    logic        [LIMIT_W-1:0]  output_limit;
    logic        [GATE_W-1:0]   max_error;
    logic        [GATE_W-1:0]   deadband_width;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_out;
    logic                     gated;
  } result_t;

endpackage

### rtl/core/pid_position_incremental_core.sv
// Top level of the PID controller core with positional and incremental modes.
//
//   Channel   Signals                                  Moves
//   --------  ---------------------------------------  ------------------------------
//   sample    sample_valid, sample_stall, sample_data  setpoint and measured per tick
//   result    result_valid, result_stall, result_data  drive_out and gated flag
//   config    cfg_we, cfg_index, cfg_data              register writes, no read-back
//
// A sample transfer is captured in an input register; from there the
// error, gating, three gain multiplies, sums and clamps are evaluated in one
// combinational pass and land in the result register. One sample per cycle
// is sustained while result_stall is low; the state update, skipped when gated,
// happens in the same cycle the result is registered, so the next sample always sees it.
// Synchronous reset clears the valid flags, the configuration and the state.
// A stalled result holds in place; the input register keeps accepting while
// the result register can take its content, otherwise sample_stall rises.
module pid_position_incremental_core #(
  parameter int GAIN_FRAC_BITS = pidpi_pkg::GAIN_FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  pidpi_pkg::sample_t                 sample_data,
  output logic                               result_valid,
  input  logic                               result_stall,
  output pidpi_pkg::result_t                 result_data,
  input  logic                               cfg_we,
  input  logic [pidpi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pidpi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pidpi_pkg::cfg_t    cfg;
  pidpi_pkg::sample_t hold;
  logic               hold_valid;
  pidpi_pkg::result_t result_next;
  logic               advance;

  pidpi_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held sample moves on whenever the result register is empty or its
  // current content is being transferred out this cycle.
  assign advance      = hold_valid && (!result_valid || !result_stall);
  assign sample_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!sample_stall) begin
      hold_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      hold <= sample_data;
    end
  end

  pidpi_datapath #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .sample (hold),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data <= result_next;
    end
  end

endmodule

### rtl/core/pidpi_cfg_regs.sv
// Configuration register file for the PID position/incremental core.
module pidpi_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pidpi_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pidpi_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pidpi_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (pidpi_pkg::cfg_index_t'(cfg_index))
        pidpi_pkg::REG_CONTROL_MODE: begin
          cfg.control_mode <= pidpi_pkg::control_mode_t'(cfg_data[0]);
        end
        pidpi_pkg::REG_GAIN_P: begin
          cfg.gain_p <= signed'(cfg_data[pidpi_pkg::GAIN_W-1:0]);
        end
        pidpi_pkg::REG_GAIN_I: begin
          cfg.gain_i <= signed'(cfg_data[pidpi_pkg::GAIN_W-1:0]);
        end
        pidpi_pkg::REG_GAIN_D: begin
          cfg.gain_d <= signed'(cfg_data[pidpi_pkg::GAIN_W-1:0]);
        end
        pidpi_pkg::REG_INTEGRAL_LIMIT: begin
          cfg.integral_limit <= cfg_data[pidpi_pkg::LIMIT_W-1:0];
        end
        pidpi_pkg::REG_OUTPUT_LIMIT: begin
          cfg.output_limit <= cfg_data[pidpi_pkg::LIMIT_W-1:0];
        end
        pidpi_pkg::REG_MAX_ERROR: begin
          cfg.max_error <= cfg_data[pidpi_pkg::GATE_W-1:0];
        end
        pidpi_pkg::REG_DEADBAND_WIDTH: begin
          cfg.deadband_width <= cfg_data[pidpi_pkg::GATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/pidpi_term.sv
// One gain term: signed gain times error expression, scaled down and truncated toward zero.
module pidpi_term #(
  parameter int GAIN_FRAC_BITS = pidpi_pkg::GAIN_FRAC_BITS_DEFAULT
) (
  input  logic signed [pidpi_pkg::GAIN_W-1:0]                             gain,
  input  logic signed [pidpi_pkg::DERR_W-1:0]                             x,
  output logic signed [pidpi_pkg::GAIN_W+pidpi_pkg::DERR_W-GAIN_FRAC_BITS-1:0] term
);

  localparam int PROD_W = pidpi_pkg::GAIN_W + pidpi_pkg::DERR_W;
  localparam logic [PROD_W-1:0] ROUND_UP =
    PROD_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;

  // Negative products get 2^F-1 added before the arithmetic shift so the
  // quotient truncates toward zero rather than toward minus infinity.
  always_comb begin
    prod   = PROD_W'(gain) * PROD_W'(x);
    biased = prod + (prod[PROD_W-1] ? signed'(ROUND_UP) : signed'(PROD_W'(0)));
  end

  assign term = biased[PROD_W-1:GAIN_FRAC_BITS];

endmodule

### rtl/core/pidpi_datapath.sv
// Error, gating, PID terms, clamps and controller state for the PID core.
module pidpi_datapath #(
  parameter int GAIN_FRAC_BITS = pidpi_pkg::GAIN_FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  pidpi_pkg::cfg_t      cfg,
  input  pidpi_pkg::sample_t   sample,
  output pidpi_pkg::result_t   result
);

  localparam int DATA_W  = pidpi_pkg::DATA_W;
  localparam int ERR_W   = pidpi_pkg::ERR_W;
  localparam int DERR_W  = pidpi_pkg::DERR_W;
  localparam int TERM_W  = pidpi_pkg::GAIN_W + DERR_W - GAIN_FRAC_BITS;
  localparam int SUM_W   = TERM_W + 2;

  function automatic logic signed [DATA_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0]             v,
    input logic [pidpi_pkg::LIMIT_W-1:0]       lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = signed'(SUM_W'(lim));
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[DATA_W-1:0];
  endfunction

  // Controller state.
  logic signed [ERR_W-1:0]  error_prev;
  logic signed [ERR_W-1:0]  error_prev2;
  logic signed [DATA_W-1:0] integral_sum;
  logic signed [DATA_W-1:0] last_incremental_out;

  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  mag;
  logic                     gate;
  logic                     incr;
  logic signed [DERR_W-1:0] err_ext;
  logic signed [DERR_W-1:0] diff1;
  logic signed [DERR_W-1:0] diff2;
  logic signed [DERR_W-1:0] p_x;
  logic signed [DERR_W-1:0] d_x;
  logic signed [TERM_W-1:0] p_term;
  logic signed [TERM_W-1:0] i_term;
  logic signed [TERM_W-1:0] d_term;
  logic signed [DATA_W-1:0] integral_next;
  logic signed [DATA_W-1:0] drive_next;
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  total;

  always_comb begin
    err     = ERR_W'(sample.setpoint) - ERR_W'(sample.measured);
    mag     = err[ERR_W-1] ? unsigned'(-err) : unsigned'(err);
    gate    = ((cfg.max_error != '0) && (mag > ERR_W'(cfg.max_error))) ||
              ((cfg.deadband_width != '0) && (mag < ERR_W'(cfg.deadband_width)));
    incr    = (cfg.control_mode == pidpi_pkg::MODE_INCREMENTAL);
    err_ext = DERR_W'(err);
    diff1   = err_ext - DERR_W'(error_prev);
    diff2   = diff1 - DERR_W'(error_prev) + DERR_W'(error_prev2);
    p_x     = incr ? diff1 : err_ext;
    d_x     = incr ? diff2 : diff1;
  end

  pidpi_term #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_term_p (
    .gain (cfg.gain_p),
    .x    (p_x),
    .term (p_term)
  );

  pidpi_term #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_term_i (
    .gain (cfg.gain_i),
    .x    (err_ext),
    .term (i_term)
  );

  pidpi_term #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_term_d (
    .gain (cfg.gain_d),
    .x    (d_x),
    .term (d_term)
  );

  // Positional mode accumulates into the integral; incremental mode
  // replaces it with this tick's clamped I term.
  always_comb begin
    if (incr) begin
      integral_next = clamp_sym(SUM_W'(i_term), cfg.integral_limit);
      base          = SUM_W'(last_incremental_out);
    end else begin
      integral_next = clamp_sym(SUM_W'(integral_sum) + SUM_W'(i_term),
                                cfg.integral_limit);
      base          = '0;
    end
    total      = base + SUM_W'(p_term) + SUM_W'(integral_next) + SUM_W'(d_term);
    drive_next = clamp_sym(total, cfg.output_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_prev           <= '0;
      error_prev2          <= '0;
      integral_sum         <= '0;
      last_incremental_out <= '0;
    end else if (step && !gate) begin
      error_prev2  <= error_prev;
      error_prev   <= err;
      integral_sum <= integral_next;
      if (incr) begin
        last_incremental_out <= drive_next;
      end
    end
  end

  assign result.drive_out = gate ? '0 : drive_next;
  assign result.gated     = gate;

endmodule
